/* hw/rtl/tbpr_pkg.sv */
// Shared types and constants of the tile background pixel renderer.
`timescale 1ns / 1ps

package tbpr_pkg;

    localparam int VRAM_BYTES     = 8192;
    localparam int VRAM_AW        = $clog2(VRAM_BYTES);
    localparam int SCREEN_COLUMNS = 160;
    localparam int SCREEN_ROWS    = 144;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VRAM_AW-1:0] MAP_BASE   = VRAM_AW'(16'h1800);
    localparam logic [VRAM_AW-1:0] MAP_STRIDE = VRAM_AW'(16'h0400);

    // Configuration register indexes
    localparam logic [2:0] CFG_DISPLAY_ENABLE = 3'd0;
    localparam logic [2:0] CFG_MAP_SELECT     = 3'd1;
    localparam logic [2:0] CFG_SCROLL_X       = 3'd2;
    localparam logic [2:0] CFG_SCROLL_Y       = 3'd3;
    localparam logic [2:0] CFG_PALETTE        = 3'd4;

    localparam logic [7:0] PALETTE_RESET = 8'd252;

    // Function codes of an input word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_PIXEL,
        KIND_BLANK
    } t_kind;

    // One classified job: a write, a pixel lookup, or a blank pixel
    typedef struct packed {
        t_kind              kind;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
        logic [2:0]         fine_x;
        logic [2:0]         fine_y;
    } t_job;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TILE,
        ST_LO,
        ST_HI
    } t_back_state;

endpackage

/* hw/rtl/tbpr_front.sv */
// Front end: classifies input words and computes the tile map address.
`timescale 1ns / 1ps

module tbpr_front (
    input  logic                          i_start,
    input  logic                          i_func,
    input  logic [tbpr_pkg::VRAM_AW-1:0]  i_vram_address,
    input  logic [7:0]                    i_vram_data,
    input  logic [7:0]                    i_screen_x,
    input  logic [7:0]                    i_screen_y,
    input  logic                          i_display_enable,
    input  logic                          i_map_select,
    input  logic [7:0]                    i_scroll_x,
    input  logic [7:0]                    i_scroll_y,
    input  tbpr_pkg::t_q_status           i_q_status,
    output logic                          o_busy,
    output logic                          o_push,
    output tbpr_pkg::t_job                o_job
);

    logic [7:0]                   bg_x;
    logic [7:0]                   bg_y;
    logic                         off_screen;
    logic [tbpr_pkg::VRAM_AW-1:0] map_addr;

    // Scroll into the 256x256 background, wrapping
    assign bg_x = i_screen_x + i_scroll_x;
    assign bg_y = i_screen_y + i_scroll_y;

    assign off_screen = ({1'b0, i_screen_x} >= 9'(tbpr_pkg::SCREEN_COLUMNS))
                     || ({1'b0, i_screen_y} >= 9'(tbpr_pkg::SCREEN_ROWS));

    assign map_addr = tbpr_pkg::MAP_BASE
                    + (i_map_select ? tbpr_pkg::MAP_STRIDE : '0)
                    + tbpr_pkg::VRAM_AW'({bg_y[7:3], bg_x[7:3]});

    assign o_busy = i_q_status.full;
    assign o_push = i_start && !i_q_status.full;

    // Classify the word
    always_comb begin
        o_job.fine_x = bg_x[2:0];
        o_job.fine_y = bg_y[2:0];
        o_job.data   = i_vram_data;
        if (i_func == tbpr_pkg::FUNC_WRITE) begin
            o_job.kind = tbpr_pkg::KIND_WRITE;
            o_job.addr = i_vram_address;
        end else if (!i_display_enable || off_screen) begin
            o_job.kind = tbpr_pkg::KIND_BLANK;
            o_job.addr = map_addr;
        end else begin
            o_job.kind = tbpr_pkg::KIND_PIXEL;
            o_job.addr = map_addr;
        end
    end

endmodule

/* hw/rtl/tbpr_queue.sv */
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module tbpr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tbpr_pkg::t_job       i_job,
    input  logic                 i_pop,
    output tbpr_pkg::t_job       o_head,
    output tbpr_pkg::t_q_status  o_status
);

    tbpr_pkg::t_job                  r_slot [tbpr_pkg::QUEUE_DEPTH];
    logic [tbpr_pkg::QUEUE_PW-1:0]   r_wr_ptr;
    logic [tbpr_pkg::QUEUE_PW-1:0]   r_rd_ptr;
    logic [tbpr_pkg::QUEUE_CW-1:0]   r_count;
    logic [tbpr_pkg::QUEUE_PW-1:0]   n_wr_ptr;
    logic [tbpr_pkg::QUEUE_PW-1:0]   n_rd_ptr;
    logic [tbpr_pkg::QUEUE_CW-1:0]   n_count;

    assign o_status.full  = (r_count == tbpr_pkg::QUEUE_CW'(tbpr_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_slot[r_rd_ptr];

    // Advance pointers, wrapping at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == tbpr_pkg::QUEUE_PW'(tbpr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == tbpr_pkg::QUEUE_PW'(tbpr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* hw/rtl/tbpr_back.sv */
// Back end: video memory, tile fetch sequencer and palette lookup.
`timescale 1ns / 1ps

module tbpr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbpr_pkg::t_job       i_head,
    input  tbpr_pkg::t_q_status  i_q_status,
    input  logic [7:0]           i_palette,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [1:0]           o_shade,
    output logic                 o_display_on
);

    logic [7:0]                   r_vram [tbpr_pkg::VRAM_BYTES];
    logic [7:0]                   r_rd_data;
    tbpr_pkg::t_back_state        r_state;
    tbpr_pkg::t_back_state        n_state;
    logic [2:0]                   r_fine_x;
    logic [2:0]                   r_fine_y;
    logic [7:0]                   r_tile;
    logic [7:0]                   r_lo;
    logic                         r_strobe;
    logic [1:0]                   r_shade;
    logic                         r_display_on;

    logic                         mem_we;
    logic                         rd_en;
    logic [tbpr_pkg::VRAM_AW-1:0] rd_addr;
    logic                         take_pixel;
    logic                         take_lo;
    logic                         emit_blank;
    logic                         emit_pixel;
    logic [2:0]                   bit_sel;
    logic [1:0]                   colour;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbpr_pkg::ST_IDLE: begin
                if (!i_q_status.empty && i_head.kind == tbpr_pkg::KIND_PIXEL) begin
                    n_state = tbpr_pkg::ST_TILE;
                end
            end
            tbpr_pkg::ST_TILE: n_state = tbpr_pkg::ST_LO;
            tbpr_pkg::ST_LO:   n_state = tbpr_pkg::ST_HI;
            tbpr_pkg::ST_HI:   n_state = tbpr_pkg::ST_IDLE;
            default:           n_state = tbpr_pkg::ST_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb begin
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = i_head.addr;
        take_pixel = 1'b0;
        take_lo    = 1'b0;
        emit_blank = 1'b0;
        emit_pixel = 1'b0;
        case (r_state)
            tbpr_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        tbpr_pkg::KIND_WRITE: mem_we = 1'b1;
                        tbpr_pkg::KIND_PIXEL: begin
                            rd_en      = 1'b1;
                            take_pixel = 1'b1;
                        end
                        default: emit_blank = 1'b1;
                    endcase
                end
            end
            tbpr_pkg::ST_TILE: begin
                // Tile byte is back: fetch the low plane of the row
                rd_en   = 1'b1;
                rd_addr = tbpr_pkg::VRAM_AW'({r_rd_data, r_fine_y, 1'b0});
            end
            tbpr_pkg::ST_LO: begin
                rd_en   = 1'b1;
                rd_addr = tbpr_pkg::VRAM_AW'({r_tile, r_fine_y, 1'b1});
                take_lo = 1'b1;
            end
            tbpr_pkg::ST_HI: emit_pixel = 1'b1;
            default: ;
        endcase
    end

    // Hold the tile number for the high plane fetch
    always_ff @(posedge i_clk) begin
        if (r_state == tbpr_pkg::ST_TILE) begin
            r_tile <= r_rd_data;
        end
    end

    // Pick the colour bits of the pixel column
    assign bit_sel = ~r_fine_x;
    assign colour  = {r_rd_data[bit_sel], r_lo[bit_sel]};

    // Video memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[i_head.addr] <= i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_vram[rd_addr];
        end
    end

    // Latch the pixel offsets and the low plane
    always_ff @(posedge i_clk) begin
        if (take_pixel) begin
            r_fine_x <= i_head.fine_x;
            r_fine_y <= i_head.fine_y;
        end
        if (take_lo) begin
            r_lo <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tbpr_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit_blank || emit_pixel;
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (emit_pixel) begin
            r_shade      <= i_palette[{colour, 1'b0} +: 2];
            r_display_on <= 1'b1;
        end else if (emit_blank) begin
            r_shade      <= 2'd0;
            r_display_on <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_shade      = r_shade;
    assign o_display_on = r_display_on;

endmodule

/* hw/rtl/tile_background_pixel_renderer_unit.sv */
// A rendered pixel holds the sequencer (ST_TILE, ST_LO, ST_HI) for three dependent
// reads on the single video memory read port, taking no other job meanwhile; one write or
// blank pixel per cycle while idle; a 2-word queue buffers input; results are registered.
// The receiver cannot stall: each result is shown for exactly one cycle with o_strobe.
// Reset (synchronous, active low) clears the queue, sequencer and config registers;
// video memory holds no reset value and must be written before it is read.
`timescale 1ns / 1ps

module tile_background_pixel_renderer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_func,
    input  logic [tbpr_pkg::VRAM_AW-1:0]  i_vram_address,
    input  logic [7:0]                    i_vram_data,
    input  logic [7:0]                    i_screen_x,
    input  logic [7:0]                    i_screen_y,
    output logic                          o_strobe,
    output logic [1:0]                    o_shade,
    output logic                          o_display_on,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    logic                 r_display_enable;
    logic                 r_map_select;
    logic [7:0]           r_scroll_x;
    logic [7:0]           r_scroll_y;
    logic [7:0]           r_palette;

    logic                 push;
    logic                 pop;
    tbpr_pkg::t_job       job;
    tbpr_pkg::t_job       head;
    tbpr_pkg::t_q_status  q_status;

    assign o_cfg_ready = 1'b1;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b0;
            r_map_select     <= 1'b0;
            r_scroll_x       <= 8'd0;
            r_scroll_y       <= 8'd0;
            r_palette        <= tbpr_pkg::PALETTE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbpr_pkg::CFG_DISPLAY_ENABLE: r_display_enable <= i_cfg_data[0];
                tbpr_pkg::CFG_MAP_SELECT:     r_map_select     <= i_cfg_data[0];
                tbpr_pkg::CFG_SCROLL_X:       r_scroll_x       <= i_cfg_data;
                tbpr_pkg::CFG_SCROLL_Y:       r_scroll_y       <= i_cfg_data;
                tbpr_pkg::CFG_PALETTE:        r_palette        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tbpr_front u_front (
        .i_start          (i_start),
        .i_func           (i_func),
        .i_vram_address   (i_vram_address),
        .i_vram_data      (i_vram_data),
        .i_screen_x       (i_screen_x),
        .i_screen_y       (i_screen_y),
        .i_display_enable (r_display_enable),
        .i_map_select     (r_map_select),
        .i_scroll_x       (r_scroll_x),
        .i_scroll_y       (r_scroll_y),
        .i_q_status       (q_status),
        .o_busy           (o_busy),
        .o_push           (push),
        .o_job            (job)
    );

    tbpr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    tbpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_status   (q_status),
        .i_palette    (r_palette),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_shade      (o_shade),
        .o_display_on (o_display_on)
    );

endmodule
